@@ hdl/scfp_pkg.sv @@
// Shared types, character codes and helpers for the serial command frame parser.
// No dependencies; imported by scfp_core and serial_command_frame_parser.
package scfp_pkg;

    localparam int VALUE_CHARS = 7;
    localparam int OUT_CHARS   = 7;
    localparam int LEN_CHARS   = (VALUE_CHARS < OUT_CHARS) ? VALUE_CHARS : OUT_CHARS;
    localparam int CNT_W       = $clog2(VALUE_CHARS + 1);
    localparam int IDX_W       = (VALUE_CHARS > 1) ? $clog2(VALUE_CHARS) : 1;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_R     = 8'h72;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CAR   = 8'b0000_0010,
        ST_READY = 8'b0000_0100,
        ST_GET   = 8'b0000_1000,
        ST_SET   = 8'b0001_0000,
        ST_PARAM = 8'b0010_0000,
        ST_VALUE = 8'b0100_0000,
        ST_WAIT  = 8'b1000_0000
    } scfp_state_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_MOTOR     = 3'd1,
        EV_GET_LOCAL = 3'd2,
        EV_GET_FWD   = 3'd3,
        EV_SET_LOCAL = 3'd4,
        EV_SET_FWD   = 3'd5,
        EV_ANSWER    = 3'd6
    } scfp_event_t;

    typedef struct packed {
        scfp_event_t           kind;
        logic [1:0]            dir;
        logic [7:0]            param;
        logic [8*OUT_CHARS-1:0] text;
        logic [2:0]            length;
    } scfp_result_t;

    function automatic logic letter_ok(input logic [7:0] c);
        return c inside {8'h76, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, CH_L, CH_R, 8'h6F};
    endfunction

    function automatic logic value_char(input logic [7:0] c);
        return c inside {[CH_0:CH_9], CH_COMMA};
    endfunction

endpackage

@@ hdl/serial_command_frame_parser.sv @@
// Top level of the serial command frame parser: input handshake and result register.
// Depends on scfp_pkg and scfp_core.
// A result item is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the input is not stalled; a single result register follows the parser step.
// Input stalls only while a held result is itself stalled at the output.
// Reset (rst_n, async, active low) returns the parser to idle, leader role, wait flag clear.
module serial_command_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [1:0]  motor_dir,
    output logic [7:0]  param_code,
    output logic [55:0] value_text,
    output logic [2:0]  value_length
);
    import scfp_pkg::*;

    scfp_result_t result;
    scfp_result_t result_reg;
    logic         out_valid_reg;
    logic         step;

    assign in_stall = out_valid_reg && out_stall;
    assign step     = in_valid && !in_stall;

    scfp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx_byte),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = result_reg.kind;
    assign motor_dir    = result_reg.dir;
    assign param_code   = result_reg.param;
    assign value_text   = result_reg.text;
    assign value_length = result_reg.length;

    a_dir_motor_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.kind != EV_MOTOR) |-> (result_reg.dir == 2'd0))
        else $error("motor direction set on non-motor item");

    a_param_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.kind == EV_NONE || result_reg.kind == EV_MOTOR
                           || result_reg.kind == EV_ANSWER)) |-> (result_reg.param == 8'd0))
        else $error("parameter code on item without parameter");

    a_empty_text: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.length == 3'd0) |-> (result_reg.text == '0))
        else $error("value text without length");

endmodule

@@ hdl/scfp_core.sv @@
// Frame parser state, value store and per-byte event decode.
// Depends on scfp_pkg; the result is registered by serial_command_frame_parser.
module scfp_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    output scfp_pkg::scfp_result_t result
);
    import scfp_pkg::*;

    scfp_state_t       state_reg, state_next;
    logic              follower_reg, follower_next;
    logic              wait_reg, wait_next;
    logic [7:0]        param_reg, param_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        store_reg [VALUE_CHARS];
    logic              store_we;
    logic [8*OUT_CHARS-1:0] text_cur;

    // Gather written characters; bytes past the count stay zero.
    always_comb
    begin
        text_cur = '0;
        for (int i = 0; i < LEN_CHARS; i++)
        begin
            if (i < int'(count_reg))
            begin
                text_cur[8*i +: 8] = store_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        follower_next = follower_reg;
        wait_next     = wait_reg;
        param_next    = param_reg;
        count_next    = count_reg;
        store_we      = 1'b0;
        result        = '0;

        if (rx_byte == CH_HASH)
        begin
            state_next = ST_CAR;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (rx_byte inside {[CH_1:CH_4]})
                    begin
                        result.kind = EV_MOTOR;
                        result.dir  = 2'(rx_byte - CH_1);
                    end
                end
                ST_CAR:
                begin
                    if (rx_byte == CH_1)
                    begin
                        follower_next = 1'b0;
                        state_next    = ST_READY;
                    end
                    else if (rx_byte == CH_2)
                    begin
                        follower_next = 1'b1;
                        state_next    = ST_READY;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_READY:
                begin
                    if (rx_byte == CH_G)
                        state_next = ST_GET;
                    else if (rx_byte == CH_S)
                        state_next = ST_SET;
                    else
                        state_next = ST_IDLE;
                end
                ST_GET:
                begin
                    if (letter_ok(rx_byte))
                    begin
                        param_next = rx_byte;
                        state_next = ST_PARAM;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_SET:
                begin
                    if (letter_ok(rx_byte))
                    begin
                        param_next = rx_byte;
                        count_next = '0;
                        state_next = ST_VALUE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_PARAM:
                begin
                    if (rx_byte == CH_SEMI)
                    begin
                        if (follower_reg)
                        begin
                            result.kind  = EV_GET_FWD;
                            result.param = param_reg;
                            wait_next    = 1'b1;
                        end
                        else if (param_reg != CH_V)
                        begin
                            result.kind  = EV_GET_LOCAL;
                            result.param = param_reg;
                        end
                    end
                    // Route on the flag as updated by this byte
                    if (wait_next)
                    begin
                        state_next = ST_WAIT;
                        count_next = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_VALUE, ST_WAIT:
                begin
                    if (value_char(rx_byte))
                    begin
                        // Drop characters past the store depth
                        if (int'(count_reg) < VALUE_CHARS)
                        begin
                            store_we   = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (rx_byte == CH_SEMI)
                        begin
                            if (state_reg == ST_WAIT)
                            begin
                                result.kind   = EV_ANSWER;
                                result.text   = text_cur;
                                result.length = 3'(count_reg);
                            end
                            else if (follower_reg ? (param_reg != CH_L && param_reg != CH_R)
                                                  : (param_reg != CH_V && param_reg != CH_L
                                                     && param_reg != CH_R))
                            begin
                                result.kind   = follower_reg ? EV_SET_FWD : EV_SET_LOCAL;
                                result.param  = param_reg;
                                result.text   = text_cur;
                                result.length = 3'(count_reg);
                            end
                        end
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            follower_reg <= 1'b0;
            wait_reg     <= 1'b0;
            param_reg    <= '0;
            count_reg    <= '0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            follower_reg <= follower_next;
            wait_reg     <= wait_next;
            param_reg    <= param_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && store_we)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    a_wait_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(wait_reg) |-> wait_reg)
        else $error("wait flag cleared");

    a_wait_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> wait_reg)
        else $error("answer state without wait flag");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= VALUE_CHARS)
        else $error("value count past store depth");

endmodule
